// ----- sv/kdf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdf_pkg
// Types, constants and codes shared by the key debounce event FIFO block.
// ----------------------------------------------------------------------------
package kdf_pkg;

  localparam int KEYS_DEF  = 9;
  localparam int DEPTH_DEF = 16;

  localparam int ADC_W  = 10;
  localparam int CODE_W = 8;
  localparam int MAP_W  = 9;
  localparam int CNT_W  = 6;
  localparam int FILT_W = 5;
  localparam int HOLD_W = 16;
  localparam int REP_W  = 8;
  localparam int LVL_W  = 40;
  localparam int CMD_W  = 3;
  localparam int RIDX_W = 3;

  localparam logic [ADC_W-1:0] ADC_MAX = 10'd1023;

  localparam logic [FILT_W-1:0] FILT_RST  = 5'd5;
  localparam logic [CNT_W-1:0]  COUNT_RST = CNT_W'(FILT_RST / 2);

  typedef enum logic [CMD_W-1:0] {
    CMD_SCAN   = 3'd0,
    CMD_POP_A  = 3'd1,
    CMD_POP_B  = 3'd2,
    CMD_CLR_A  = 3'd3,
    CMD_INJECT = 3'd4
  } cmd_e;

  typedef enum logic [RIDX_W-1:0] {
    REG_FILTER_TIME  = 3'd0,
    REG_LONG_TIME    = 3'd1,
    REG_REPEAT_SPEED = 3'd2,
    REG_AD_TOLERANCE = 3'd3,
    REG_LEVELS_CH0   = 3'd4,
    REG_LEVELS_CH1   = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUSH2,
    ST_OP,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADC_W-1:0]  adc_sample_a;
    logic [ADC_W-1:0]  adc_sample_b;
    logic              pin_level;
    logic [CODE_W-1:0] inject_code;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] key_code;
    logic [MAP_W-1:0]  pressed_map;
  } out_word_t;

  typedef struct packed {
    logic [RIDX_W-1:0] reg_index;
    logic [LVL_W-1:0]  wdata;
  } cfg_word_t;

  typedef struct packed {
    logic [FILT_W-1:0] filter_time;
    logic [HOLD_W-1:0] long_time;
    logic [REP_W-1:0]  repeat_speed;
    logic [ADC_W-1:0]  ad_tolerance;
    logic [LVL_W-1:0]  levels_ch0;
    logic [LVL_W-1:0]  levels_ch1;
  } key_cfg_t;

  localparam key_cfg_t CFG_RST = '{
    filter_time:  FILT_RST,
    long_time:    16'd100,
    repeat_speed: 8'd0,
    ad_tolerance: 10'd5,
    levels_ch0:   40'd927920084,
    levels_ch1:   40'd946965792735
  };

  typedef struct packed {
    logic              push1;
    logic [CODE_W-1:0] code1;
    logic              push2;
    logic [CODE_W-1:0] code2;
  } key_res_t;

  typedef struct packed {
    logic              push;
    logic [CODE_W-1:0] code;
    logic              pop_a;
    logic              pop_b;
    logic              clr_a;
  } fifo_ctl_t;

endpackage

// ----- sv/kdf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdf_if
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface kdf_in_if;
  import kdf_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kdf_out_if;
  import kdf_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kdf_cfg_if;
  import kdf_pkg::*;
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/key_debounce_event_fifo_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_event_fifo_top
// Nine-key scanner with debounce, long press, repeat and a two-reader FIFO.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : command word (scan tick, pop A, pop B, clear A, inject) plus
//            ADC samples, pin level and inject code.
//   out_ch : one result word per command: popped code and pressed map.
//   cfg_ch : register writes, always ready; write only while idle.
// Timing:
//   A scan tick walks the keys through one shared key update unit, one key
//   per cycle; a key that emits a second event word holds the walk in ST_PUSH2.
//   A scan ends in ST_RESULT; the other commands pass through ST_OP and
//   ST_RESULT (pops via the registered FIFO memory read). One command is in
//   work at a time.
// Reset: counts go to half the filter time, flags and pointers clear; FIFO
//   memory is not cleared. Registers return to their defaults.
// Stall: the result sits in an output register; the next command is taken
//   while it waits, and its own result holds until the register frees.
// ----------------------------------------------------------------------------
module key_debounce_event_fifo_top
  import kdf_pkg::*;
#(
  parameter int NUM_KEYS   = KEYS_DEF,
  parameter int FIFO_DEPTH = DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  kdf_in_if.sink     in_ch,
  kdf_out_if.source  out_ch,
  kdf_cfg_if.sink    cfg_ch
);

  localparam int KIDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [KIDX_W-1:0] KEY_LAST = KIDX_W'(NUM_KEYS - 1);

  state_t            state_r, state_nxt;
  key_cfg_t          cfg_r;
  logic [KIDX_W-1:0] key_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [ADC_W-1:0]  samp_a_r, samp_b_r;
  logic              pin_r;
  logic [CODE_W-1:0] inj_r, code2_r;
  logic              out_valid_r;
  out_word_t         out_data_r;

  logic              in_ready, in_acc, cfg_acc, rep_clr;
  logic              step_en, key_adv, out_free, out_load, last_key, is_pop;
  key_res_t          kres;
  fifo_ctl_t         fctl;
  logic [CODE_W-1:0] rd_data;
  logic              rd_hit;
  logic [MAP_W-1:0]  pressed_map;

  assign in_acc   = in_ch.valid && in_ready;
  assign cfg_acc  = cfg_ch.valid;
  assign out_free = !out_valid_r || out_ch.ready;
  assign last_key = (key_r == KEY_LAST);
  assign is_pop   = (cmd_r == CMD_POP_A) || (cmd_r == CMD_POP_B);
  assign rep_clr  = cfg_acc && ((cfg_ch.data.reg_index == REG_LONG_TIME) ||
                                (cfg_ch.data.reg_index == REG_REPEAT_SPEED));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_ch.data.cmd == CMD_SCAN) ? ST_SCAN : ST_OP;
        end
      end
      ST_SCAN: begin
        if (kres.push2) begin
          state_nxt = ST_PUSH2;
        end else if (last_key) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_PUSH2:  state_nxt = last_key ? ST_RESULT : ST_SCAN;
      ST_OP:     state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    step_en    = 1'b0;
    key_adv    = 1'b0;
    out_load   = 1'b0;
    fctl       = '0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: begin
        step_en    = 1'b1;
        key_adv    = !kres.push2 && !last_key;
        fctl.push  = kres.push1;
        fctl.code  = kres.code1;
      end
      ST_PUSH2: begin
        key_adv   = !last_key;
        fctl.push = 1'b1;
        fctl.code = code2_r;
      end
      ST_OP: begin
        case (cmd_r)
          CMD_POP_A:  fctl.pop_a = 1'b1;
          CMD_POP_B:  fctl.pop_b = 1'b1;
          CMD_CLR_A:  fctl.clr_a = 1'b1;
          CMD_INJECT: begin
            fctl.push = 1'b1;
            fctl.code = inj_r;
          end
          default:    fctl = '0;
        endcase
      end
      ST_RESULT: out_load = out_free;
      default:   in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      key_r       <= '0;
      out_valid_r <= 1'b0;
      cfg_r       <= CFG_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) begin
        key_r <= '0;
      end else if (key_adv) begin
        key_r <= key_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_acc) begin
        case (cfg_ch.data.reg_index)
          REG_FILTER_TIME:  cfg_r.filter_time  <= cfg_ch.data.wdata[FILT_W-1:0];
          REG_LONG_TIME:    cfg_r.long_time    <= cfg_ch.data.wdata[HOLD_W-1:0];
          REG_REPEAT_SPEED: cfg_r.repeat_speed <= cfg_ch.data.wdata[REP_W-1:0];
          REG_AD_TOLERANCE: cfg_r.ad_tolerance <= cfg_ch.data.wdata[ADC_W-1:0];
          REG_LEVELS_CH0:   cfg_r.levels_ch0   <= cfg_ch.data.wdata;
          REG_LEVELS_CH1:   cfg_r.levels_ch1   <= cfg_ch.data.wdata;
          default:          cfg_r              <= cfg_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_ch.data.cmd;
      samp_a_r <= in_ch.data.adc_sample_a;
      samp_b_r <= in_ch.data.adc_sample_b;
      pin_r    <= in_ch.data.pin_level;
      inj_r    <= in_ch.data.inject_code;
    end
    if (step_en) begin
      code2_r <= kres.code2;
    end
    if (out_load) begin
      out_data_r.key_code    <= (is_pop && rd_hit) ? rd_data : '0;
      out_data_r.pressed_map <= pressed_map;
    end
  end

  kdf_key_unit #(
    .NUM_KEYS (NUM_KEYS)
  ) u_key (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step_en),
    .key_idx     (key_r),
    .cfg         (cfg_r),
    .rep_clr     (rep_clr),
    .sample_a    (samp_a_r),
    .sample_b    (samp_b_r),
    .pin_level   (pin_r),
    .res         (kres),
    .pressed_map (pressed_map)
  );

  kdf_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (fctl),
    .rd_data (rd_data),
    .rd_hit  (rd_hit)
  );

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

`ifndef SYNTHESIS
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) || (state_r == ST_PUSH2)) |-> (key_r <= KEY_LAST))
    else $error("key index past last key");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(fctl.push && (fctl.pop_a || fctl.pop_b)))
    else $error("push and pop in the same cycle");

  a_result_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("result load did not finish the command");
`endif

endmodule

// ----- sv/kdf_key_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdf_key_unit
// Shared per-key update: ladder window match, debounce, long press, repeat.
// ----------------------------------------------------------------------------
module kdf_key_unit
  import kdf_pkg::*;
#(
  parameter int  NUM_KEYS = KEYS_DEF,
  localparam int KIDX_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [KIDX_W-1:0] key_idx,
  input  key_cfg_t          cfg,
  input  logic              rep_clr,
  input  logic [ADC_W-1:0]  sample_a,
  input  logic [ADC_W-1:0]  sample_b,
  input  logic              pin_level,
  output key_res_t          res,
  output logic [MAP_W-1:0]  pressed_map
);

  logic [CNT_W-1:0]    cnt_r [NUM_KEYS];
  logic [NUM_KEYS-1:0] prs_r;
  logic [HOLD_W-1:0]   hold_r [NUM_KEYS];
  logic [REP_W-1:0]    rep_r [NUM_KEYS];

  logic [CNT_W-1:0]  cnt_cur, cnt_nxt;
  logic              prs_cur, prs_nxt;
  logic [HOLD_W-1:0] hold_cur, hold_nxt, hold_inc;
  logic [REP_W-1:0]  rep_cur, rep_nxt, rep_inc;

  logic [3:0]        km1;
  logic [LVL_W-1:0]  pack;
  logic [ADC_W-1:0]  level, sample, lo, hi;
  logic [ADC_W:0]    hi_sum;
  logic              down;
  logic [CNT_W-1:0]  filt1, filt2;
  logic [CODE_W-1:0] base, code_press, code_rel, code_long, sec_code;
  logic              p_press, p_rel, p_sec;

  assign cnt_cur  = cnt_r[key_idx];
  assign prs_cur  = prs_r[key_idx];
  assign hold_cur = hold_r[key_idx];
  assign rep_cur  = rep_r[key_idx];

  // ladder keys: 1..4 on channel 0, 5..8 on channel 1
  assign km1    = 4'(key_idx) - 4'd1;
  assign pack   = km1[2] ? cfg.levels_ch1 : cfg.levels_ch0;
  assign sample = km1[2] ? sample_b : sample_a;

  always_comb begin
    case (km1[1:0])
      2'd0:    level = pack[9:0];
      2'd1:    level = pack[19:10];
      2'd2:    level = pack[29:20];
      default: level = pack[39:30];
    endcase
  end

  assign lo     = (level < cfg.ad_tolerance) ? '0 : level - cfg.ad_tolerance;
  assign hi_sum = {1'b0, level} + {1'b0, cfg.ad_tolerance};
  assign hi     = (hi_sum > {1'b0, ADC_MAX}) ? ADC_MAX : hi_sum[ADC_W-1:0];
  assign down   = (key_idx == '0) ? !pin_level : ((sample >= lo) && (sample <= hi));

  assign filt1    = CNT_W'(cfg.filter_time);
  assign filt2    = {cfg.filter_time, 1'b0};
  assign hold_inc = hold_cur + 1'b1;
  assign rep_inc  = rep_cur + 1'b1;

  assign base       = (CODE_W'(key_idx) << 1) + CODE_W'(key_idx);
  assign code_press = base + 8'd1;
  assign code_rel   = base + 8'd2;
  assign code_long  = base + 8'd3;

  always_comb begin
    cnt_nxt  = cnt_cur;
    prs_nxt  = prs_cur;
    hold_nxt = hold_cur;
    rep_nxt  = rep_cur;
    p_press  = 1'b0;
    p_rel    = 1'b0;
    p_sec    = 1'b0;
    sec_code = code_long;
    if (down) begin
      if (cnt_cur < filt1) begin
        cnt_nxt = filt1;
      end else if (cnt_cur < filt2) begin
        cnt_nxt = cnt_cur + 1'b1;
      end else begin
        if (!prs_cur) begin
          prs_nxt = 1'b1;
          p_press = 1'b1;
        end
        if (cfg.long_time != '0) begin
          if (hold_cur < cfg.long_time) begin
            hold_nxt = hold_inc;
            p_sec    = (hold_inc == cfg.long_time);
          end else if (cfg.repeat_speed != '0) begin
            if (rep_inc >= cfg.repeat_speed) begin
              rep_nxt  = '0;
              p_sec    = 1'b1;
              sec_code = code_press;
            end else begin
              rep_nxt = rep_inc;
            end
          end
        end
      end
    end else begin
      if (cnt_cur > filt1) begin
        cnt_nxt = filt1;
      end else if (cnt_cur != '0) begin
        cnt_nxt = cnt_cur - 1'b1;
      end else if (prs_cur) begin
        prs_nxt = 1'b0;
        p_rel   = 1'b1;
      end
      hold_nxt = '0;
      rep_nxt  = '0;
    end
  end

  always_comb begin
    res.push1 = p_press || p_rel || p_sec;
    res.code1 = p_press ? code_press : (p_rel ? code_rel : sec_code);
    res.push2 = p_press && p_sec;
    res.code2 = sec_code;
  end

  always_comb begin
    pressed_map = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      pressed_map[i] = prs_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prs_r <= '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        cnt_r[i]  <= COUNT_RST;
        hold_r[i] <= '0;
        rep_r[i]  <= '0;
      end
    end else begin
      if (step) begin
        cnt_r[key_idx]  <= cnt_nxt;
        prs_r[key_idx]  <= prs_nxt;
        hold_r[key_idx] <= hold_nxt;
        rep_r[key_idx]  <= rep_nxt;
      end
      if (rep_clr) begin
        for (int i = 0; i < NUM_KEYS; i++) begin
          rep_r[i] <= '0;
        end
      end
    end
  end

endmodule

// ----- sv/kdf_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdf_fifo
// Event ring with one write pointer and two independent read pointers.
// ----------------------------------------------------------------------------
module kdf_fifo
  import kdf_pkg::*;
#(
  parameter int  FIFO_DEPTH = DEPTH_DEF,
  localparam int PTR_W      = $clog2(FIFO_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fifo_ctl_t         ctl,
  output logic [CODE_W-1:0] rd_data,
  output logic              rd_hit
);

  logic [CODE_W-1:0] mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_r, rda_r, rdb_r, sel;
  logic [CODE_W-1:0] rd_data_r;
  logic              rd_hit_r;
  logic              pop, hit;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop = ctl.pop_a || ctl.pop_b;
  assign sel = ctl.pop_b ? rdb_r : rda_r;
  assign hit = (sel != wr_r);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_r] <= ctl.code;
    end
    if (pop) begin
      rd_data_r <= mem[sel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r     <= '0;
      rda_r    <= '0;
      rdb_r    <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (ctl.push) begin
        wr_r <= ptr_inc(wr_r);
      end
      if (pop) begin
        rd_hit_r <= hit;
      end
      if (ctl.pop_a && hit) begin
        rda_r <= ptr_inc(rda_r);
      end
      if (ctl.pop_b && hit) begin
        rdb_r <= ptr_inc(rdb_r);
      end
      if (ctl.clr_a) begin
        rda_r <= wr_r;
      end
    end
  end

  assign rd_data = rd_data_r;
  assign rd_hit  = rd_hit_r;

endmodule
